FILE: hw/rtl/online_palindromic_length_assert.svh
// ----------------------------------------------------------------------------
// Online palindromic length: assertion macros
// Shorthands for concurrent checks clocked by clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ONLINE_PALINDROMIC_LENGTH_ASSERT_SVH
`define ONLINE_PALINDROMIC_LENGTH_ASSERT_SVH

// Same-cycle implication.
`define OPL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OPL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/opl_pkg.sv
// ----------------------------------------------------------------------------
// Online palindromic length: package
// Sizes, node and count types and the small helpers shared by the RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package opl_pkg;

	// Text capacity in bytes.
	localparam int MAX_LEN = 4096;

	localparam int POS_W      = $clog2(MAX_LEN + 1);
	localparam int TXT_AW     = $clog2(MAX_LEN);
	localparam int NODE_W     = $clog2(2 * MAX_LEN + 1);
	localparam int LINK_DEPTH = 2 * MAX_LEN + 1;
	localparam int SW_W       = NODE_W + 2;
	localparam int CNT_W      = 13;
	localparam int SYM_W      = 8;

	typedef logic [POS_W-1:0]         pos_t;
	typedef logic [NODE_W-1:0]        node_t;
	typedef logic signed [SW_W-1:0]   sw_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [SYM_W-1:0]         sym_t;

	localparam node_t HEAD_NODE = '0;
	localparam node_t TAIL_NODE = node_t'(2 * MAX_LEN);
	localparam cnt_t  INF_CNT   = cnt_t'(MAX_LEN + 1);

	// Node number as a signed value.
	function automatic sw_t node2sw(node_t n);
		return sw_t'({{(SW_W - NODE_W){1'b0}}, n});
	endfunction

	// Length of the palindrome whose centre code is v, given base 2*(i+1).
	function automatic sw_t plen(node_t v, sw_t base);
		if (v == TAIL_NODE)
			return '0;
		return base - node2sw(v);
	endfunction

endpackage

FILE: hw/rtl/opl_in_if.sv
// ----------------------------------------------------------------------------
// Online palindromic length: input channel
// Valid/ready channel carrying one text byte per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface opl_in_if import opl_pkg::*; ;
	logic valid;
	logic ready;
	sym_t symbol;

	modport source (output valid, output symbol, input ready);
	modport sink (input valid, input symbol, output ready);
endinterface

FILE: hw/rtl/opl_out_if.sv
// ----------------------------------------------------------------------------
// Online palindromic length: result channel
// Valid/ready channel carrying the palindromic length and the overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface opl_out_if import opl_pkg::*; ;
	logic valid;
	logic ready;
	cnt_t pal_length;
	logic overflow;

	modport source (output valid, output pal_length, output overflow, input ready);
	modport sink (input valid, input pal_length, input overflow, output ready);
endinterface

FILE: hw/rtl/opl_ram.sv
// ----------------------------------------------------------------------------
// Online palindromic length: generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/opl_mod.sv
// ----------------------------------------------------------------------------
// Online palindromic length: remainder unit
// Restoring division, one quotient bit per cycle; returns the remainder only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opl_mod import opl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  node_t             num,
	input  logic [NODE_W:0]   den,
	output logic              done,
	output node_t             rem
);

	localparam int CW = $clog2(NODE_W);

	logic              run_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	node_t             num_q;
	logic [NODE_W:0]   den_q;
	logic [NODE_W:0]   rem_q;
	logic [NODE_W+1:0] trial;
	logic [NODE_W+1:0] diff;

	// Shift in the next dividend bit and subtract when it fits.
	always_comb begin
		trial = {rem_q, num_q[NODE_W-1]};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NODE_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NODE_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q})
				rem_q <= diff[NODE_W:0];
			else
				rem_q <= trial[NODE_W:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q[NODE_W-1:0];

endmodule

FILE: hw/rtl/online_palindromic_length.sv
// ----------------------------------------------------------------------------
// Online palindromic length
// Returns, for each text byte, the fewest palindromes that factor the text
// read so far, using a linked list of suffix-palindrome centres in RAM.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                      handshake
//   req      in   symbol[7:0]                  valid/ready
//   rsp      out  pal_length[12:0], overflow   valid/ready
//
// After reset a clearing pass initializes the link RAMs; no item is taken
// during it. The work per item grows with the list nodes dropped or kept
// while extending and with the palindrome series in the update walk, and is
// larger when the byte repeats the one before. A full series skip is
// dominated by the 14-step remainder unit. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module online_palindromic_length import opl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	opl_in_if.sink     req,
	opl_out_if.source  rsp
);

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] S_CLR     = 5'd0;
	localparam logic [ST_W-1:0] S_IDLE    = 5'd1;
	localparam logic [ST_W-1:0] S_EX_HEAD = 5'd2;
	localparam logic [ST_W-1:0] S_EX_TEST = 5'd3;
	localparam logic [ST_W-1:0] S_EX_CHK  = 5'd4;
	localparam logic [ST_W-1:0] S_SK_U    = 5'd5;
	localparam logic [ST_W-1:0] S_SK_PU   = 5'd6;
	localparam logic [ST_W-1:0] S_SK_DIV  = 5'd7;
	localparam logic [ST_W-1:0] S_SK_TO   = 5'd8;
	localparam logic [ST_W-1:0] S_PB_RD   = 5'd9;
	localparam logic [ST_W-1:0] S_PB_WR   = 5'd10;
	localparam logic [ST_W-1:0] S_PB_WR2  = 5'd11;
	localparam logic [ST_W-1:0] S_SE_HEAD = 5'd12;
	localparam logic [ST_W-1:0] S_SE_TEST = 5'd13;
	localparam logic [ST_W-1:0] S_SE_RD   = 5'd14;
	localparam logic [ST_W-1:0] S_SU_A    = 5'd15;
	localparam logic [ST_W-1:0] S_SU_B    = 5'd16;
	localparam logic [ST_W-1:0] S_WB      = 5'd17;
	localparam logic [ST_W-1:0] S_DONE    = 5'd18;

	// Where a best-count lookup comes from.
	localparam logic [1:0] DP_ZERO = 2'd0;
	localparam logic [1:0] DP_MEM  = 2'd1;
	localparam logic [1:0] DP_CUR  = 2'd2;
	localparam logic [1:0] DP_INF  = 2'd3;

	// Skip is shared by the extension walk and the series walk.
	localparam logic MODE_EX = 1'b0;
	localparam logic MODE_SE = 1'b1;

	logic [ST_W-1:0] state_q;
	node_t           clr_q;
	pos_t            pos_q;
	sym_t            cur_q;
	sym_t            last_q;
	sw_t             base_q;
	logic            mode_q;
	logic [NODE_W-1:0] steps_q;
	node_t           v_q, u_q, nxv_q, jmp_q, to_q, pb_c_q;
	logic            pb_more_q;
	sw_t             per_q;
	logic            kneg_q, koob_q;
	logic [TXT_AW-1:0] si_q;
	logic            si_ok_q, sb_use_q;
	logic [1:0]      dpcls_q;
	cnt_t            best_q;
	cnt_t            res_len_q;
	logic            res_ovf_q;
	logic            out_valid_q;
	cnt_t            out_len_q;
	logic            out_ovf_q;

	// RAM ports.
	logic              nxt_we, prv_we, txt_we, bst_we, sbm_we;
	node_t             nxt_wa, nxt_wd, nxt_ra, nxt_rd;
	node_t             prv_wa, prv_wd, prv_ra, prv_rd;
	logic [TXT_AW-1:0] txt_wa, txt_ra, bst_wa, bst_ra, sbm_wa, sbm_ra;
	sym_t              txt_wd, txt_rd;
	cnt_t              bst_wd, bst_rd, sbm_wd, sbm_rd;

	// Remainder unit.
	logic  mod_start, mod_done;
	node_t mod_rem;

	// Combinational helpers.
	logic  accept, pos_full, walk_ok, pb_two;
	sw_t   plen_v, plen_nxv, per_u, k_s, to_s, cr_s, pto, baby, si_s, dp_s;
	node_t to_n, cr_n;
	logic  sk_fin;
	node_t sk_res;
	logic  mismatch;
	cnt_t  dp_val, cand, last_sb, last_min;

	opl_ram #(.WIDTH(NODE_W), .DEPTH(LINK_DEPTH)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.raddr(nxt_ra), .rdata(nxt_rd)
	);
	opl_ram #(.WIDTH(NODE_W), .DEPTH(LINK_DEPTH)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.raddr(prv_ra), .rdata(prv_rd)
	);
	opl_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_text (
		.clk(clk), .we(txt_we), .waddr(txt_wa), .wdata(txt_wd),
		.raddr(txt_ra), .rdata(txt_rd)
	);
	opl_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_best (
		.clk(clk), .we(bst_we), .waddr(bst_wa), .wdata(bst_wd),
		.raddr(bst_ra), .rdata(bst_rd)
	);
	opl_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_series (
		.clk(clk), .we(sbm_we), .waddr(sbm_wa), .wdata(sbm_wd),
		.raddr(sbm_ra), .rdata(sbm_rd)
	);

	opl_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start),
		.num(plen_v[NODE_W-1:0]), .den(per_q[NODE_W:0]),
		.done(mod_done), .rem(mod_rem)
	);

	assign req.ready      = (state_q == S_IDLE);
	assign accept         = req.valid && req.ready;
	assign pos_full       = (pos_q == POS_W'(MAX_LEN));
	assign rsp.valid      = out_valid_q;
	assign rsp.pal_length = out_len_q;
	assign rsp.overflow   = out_ovf_q;

	// Arithmetic on the current node and the series being jumped.
	always_comb begin
		walk_ok  = (v_q != HEAD_NODE) && (v_q < TAIL_NODE) && (steps_q <= TAIL_NODE);
		pb_two   = (pos_q != '0) && (last_q == cur_q);
		plen_v   = plen(v_q, base_q);
		plen_nxv = plen(nxv_q, base_q);
		per_u    = plen(u_q, base_q) - plen(nxt_rd, base_q);
		k_s      = node2sw(v_q) - sw_t'({{(SW_W - POS_W){1'b0}}, pos_q}) - sw_t'(1);
		to_s     = base_q - node2sw(mod_rem) - per_q;
		to_n     = to_s[NODE_W-1:0];
		cr_s     = base_q - node2sw(mod_rem);
		cr_n     = (mod_rem == '0) ? TAIL_NODE : cr_s[NODE_W-1:0];
		pto      = plen(to_q, base_q) - plen(nxt_rd, base_q);
		baby     = plen(jmp_q, base_q) + per_q;
		si_s     = sw_t'({{(SW_W - POS_W){1'b0}}, pos_q}) - plen_v + sw_t'(1);
		dp_s     = sw_t'({{(SW_W - POS_W){1'b0}}, pos_q}) + sw_t'(1) - baby;
		mismatch = kneg_q || (cur_q != (koob_q ? sym_t'(0) : txt_rd));
		case (dpcls_q)
			DP_ZERO: dp_val = '0;
			DP_MEM:  dp_val = bst_rd;
			DP_CUR:  dp_val = best_q;
			default: dp_val = INF_CNT;
		endcase
		cand     = dp_val + cnt_t'(1);
		last_sb  = (sb_use_q && si_ok_q) ? sbm_rd : INF_CNT;
		last_min = (cand < last_sb) ? cand : last_sb;
	end

	// RAM control and skip outcome per state.
	always_comb begin
		nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = HEAD_NODE;
		prv_we = 1'b0; prv_wa = '0; prv_wd = '0; prv_ra = TAIL_NODE;
		txt_we = 1'b0; txt_wa = pos_q[TXT_AW-1:0]; txt_wd = req.symbol;
		txt_ra = k_s[TXT_AW-1:0];
		bst_we = 1'b0; bst_wa = pos_q[TXT_AW-1:0]; bst_wd = best_q;
		bst_ra = '0;
		sbm_we = 1'b0; sbm_wa = si_q; sbm_wd = last_min; sbm_ra = si_s[TXT_AW-1:0];
		mod_start = 1'b0;
		sk_fin = 1'b0;
		sk_res = nxv_q;
		bst_ra = dp_s[TXT_AW-1:0] - TXT_AW'(1);
		unique case (state_q)
			S_CLR: begin
				nxt_we = 1'b1;
				nxt_wa = clr_q;
				nxt_wd = (clr_q == HEAD_NODE) ? TAIL_NODE : HEAD_NODE;
				prv_we = 1'b1;
				prv_wa = clr_q;
				prv_wd = HEAD_NODE;
			end
			S_IDLE: begin
				txt_we = accept && !pos_full;
				nxt_ra = HEAD_NODE;
			end
			S_EX_TEST, S_SE_TEST: begin
				nxt_ra = v_q;
				prv_ra = v_q;
			end
			S_EX_CHK: begin
				if (mismatch) begin
					nxt_we = 1'b1;
					nxt_wa = prv_rd;
					nxt_wd = nxt_rd;
					prv_we = 1'b1;
					prv_wa = nxt_rd;
					prv_wd = prv_rd;
				end
			end
			S_SK_U: begin
				nxt_ra = u_q;
				if (u_q == HEAD_NODE)
					sk_fin = 1'b1;
			end
			S_SK_PU: begin
				if (per_q <= 0 || per_q != per_u || plen_v < 0)
					sk_fin = 1'b1;
				else
					mod_start = 1'b1;
			end
			S_SK_DIV: begin
				nxt_ra = to_n;
				if (mod_done && !(node2sw(v_q) < to_s)) begin
					sk_fin = 1'b1;
					sk_res = cr_n;
				end
			end
			S_SK_TO: begin
				sk_fin = 1'b1;
				sk_res = (pto < per_q) ? to_q : cr_n;
			end
			S_PB_RD: prv_ra = TAIL_NODE;
			S_PB_WR: begin
				nxt_we = 1'b1;
				nxt_wa = prv_rd;
				nxt_wd = pb_c_q;
				prv_we = 1'b1;
				prv_wa = pb_c_q;
				prv_wd = prv_rd;
			end
			S_PB_WR2: begin
				nxt_we = 1'b1;
				nxt_wa = pb_c_q;
				nxt_wd = TAIL_NODE;
				prv_we = 1'b1;
				prv_wa = TAIL_NODE;
				prv_wd = pb_c_q;
				nxt_ra = HEAD_NODE;
			end
			S_SU_B: sbm_we = si_ok_q;
			S_WB:   bst_we = 1'b1;
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_EX;
			steps_q     <= '0;
		end else begin
			// A taken result empties the register unless a new one replaces it.
			if (out_valid_q && rsp.ready && (state_q != S_DONE))
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TAIL_NODE)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (pos_full) begin
							res_len_q <= '0;
							res_ovf_q <= 1'b1;
							state_q   <= S_DONE;
						end else begin
							cur_q   <= req.symbol;
							last_q  <= cur_q;
							base_q  <= sw_t'({{(SW_W - POS_W - 1){1'b0}}, pos_q, 1'b0});
							mode_q  <= MODE_EX;
							steps_q <= '0;
							best_q  <= INF_CNT;
							state_q <= S_EX_HEAD;
						end
					end
				end
				S_EX_HEAD: begin
					v_q     <= nxt_rd;
					state_q <= S_EX_TEST;
				end
				S_EX_TEST: begin
					kneg_q <= (k_s < 0);
					koob_q <= (k_s >= sw_t'(MAX_LEN));
					if (walk_ok) begin
						state_q <= S_EX_CHK;
					end else begin
						pb_c_q    <= pb_two ? node_t'({pos_q, 1'b0}) : node_t'({pos_q, 1'b1});
						pb_more_q <= pb_two;
						state_q   <= S_PB_RD;
					end
				end
				S_EX_CHK: begin
					steps_q <= steps_q + 1'b1;
					nxv_q   <= nxt_rd;
					u_q     <= prv_rd;
					if (mismatch) begin
						v_q     <= nxt_rd;
						state_q <= S_EX_TEST;
					end else begin
						state_q <= S_SK_U;
					end
				end
				S_SK_U: begin
					per_q <= plen_v - plen_nxv;
					if (!sk_fin)
						state_q <= S_SK_PU;
				end
				S_SK_PU: begin
					if (!sk_fin)
						state_q <= S_SK_DIV;
				end
				S_SK_DIV: begin
					to_q <= to_n;
					if (mod_done && !sk_fin)
						state_q <= S_SK_TO;
				end
				S_SK_TO: ;
				S_SE_HEAD: begin
					v_q     <= nxt_rd;
					state_q <= S_SE_TEST;
				end
				S_SE_TEST: begin
					state_q <= walk_ok ? S_SE_RD : S_WB;
				end
				S_SE_RD: begin
					nxv_q   <= nxt_rd;
					u_q     <= prv_rd;
					state_q <= S_SK_U;
				end
				S_PB_RD: state_q <= S_PB_WR;
				S_PB_WR: state_q <= S_PB_WR2;
				S_PB_WR2: begin
					if (pb_more_q) begin
						pb_c_q    <= node_t'({pos_q, 1'b1});
						pb_more_q <= 1'b0;
						state_q   <= S_PB_RD;
					end else begin
						base_q  <= sw_t'({{(SW_W - POS_W - 1){1'b0}}, pos_q, 1'b0}) + sw_t'(2);
						mode_q  <= MODE_SE;
						steps_q <= '0;
						state_q <= S_SE_HEAD;
					end
				end
				S_SU_A: begin
					si_q     <= si_s[TXT_AW-1:0];
					si_ok_q  <= (si_s >= 0) && (si_s < sw_t'(MAX_LEN));
					sb_use_q <= (jmp_q != nxv_q);
					if (dp_s == 0)
						dpcls_q <= DP_ZERO;
					else if (dp_s > 0 && dp_s <= sw_t'({{(SW_W - POS_W){1'b0}}, pos_q}))
						dpcls_q <= DP_MEM;
					else if (dp_s == sw_t'({{(SW_W - POS_W){1'b0}}, pos_q}) + sw_t'(1))
						dpcls_q <= DP_CUR;
					else
						dpcls_q <= DP_INF;
					state_q <= S_SU_B;
				end
				S_SU_B: begin
					if (last_min < best_q)
						best_q <= last_min;
					v_q     <= jmp_q;
					steps_q <= steps_q + 1'b1;
					state_q <= S_SE_TEST;
				end
				S_WB: begin
					pos_q     <= pos_q + 1'b1;
					res_len_q <= best_q;
					res_ovf_q <= 1'b0;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_len_q   <= res_len_q;
						out_ovf_q   <= res_ovf_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// A finished skip returns to the walk that called it.
			if (sk_fin) begin
				if (mode_q == MODE_EX) begin
					v_q     <= sk_res;
					state_q <= S_EX_TEST;
				end else begin
					jmp_q   <= sk_res;
					state_q <= S_SU_A;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/opl_chk.sv
// ----------------------------------------------------------------------------
// Online palindromic length: port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "online_palindromic_length_assert.svh"

module opl_chk import opl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input cnt_t pal_length,
	input logic overflow
);

	// A stalled result holds its payload.
	`OPL_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(pal_length) && $stable(overflow), "result changed while stalled")

	// Only one item is in work: the port closes right after an item is taken.
	`OPL_ASSERT_NXT(a_one_item, req_valid && req_ready, !req_ready,
		"request port stayed open after an item")

	// An ignored byte reports a zero length.
	`OPL_ASSERT_IMP(a_ovf_zero, rsp_valid && overflow, pal_length == '0,
		"overflow result with nonzero length")

	// A nonempty prefix needs between one and MAX_LEN palindromes.
	`OPL_ASSERT_IMP(a_len_range, rsp_valid && !overflow,
		pal_length != '0 && pal_length <= cnt_t'(MAX_LEN), "length out of range")

endmodule

bind online_palindromic_length opl_chk u_opl_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.pal_length(rsp.pal_length),
	.overflow(rsp.overflow)
);
